// ----- hdl/rbfs_pkg.sv -----
package rbfs_pkg;

  localparam int SIDE_W   = 12;
  localparam int CENTRE_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PREP,
    ST_ROOT,
    ST_WRITE
  } state_t;

  // load starts a fresh operand, step advances one digit
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_t;

endpackage

// ----- hdl/rotated_bitmap_frame_size_top.sv -----
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------
// input    | in_valid / in_ready       | bitmap_width, bitmap_height,
//          |                           | pivot_x, pivot_y
// output   | out_valid / out_ready     | frame_side, frame_centre
//
// A transaction runs from acceptance through shift-add squaring, a load of the
// root unit, the bit-serial root and a write-back to out_valid. in_ready is
// back the cycle after write-back, so a new transaction is taken only once the
// last one has been written back.
// A stalled output holds the next finished result in the root unit.
// rst is synchronous; it clears the state machine and out_valid.
module rotated_bitmap_frame_size_top
  import rbfs_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] bitmap_width,
  input  logic [COORD_BITS-1:0] bitmap_height,
  input  logic [COORD_BITS-1:0] pivot_x,
  input  logic [COORD_BITS-1:0] pivot_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SIDE_W-1:0]     frame_side,
  output logic [CENTRE_W-1:0]   frame_centre
);

  localparam int CNT_W    = $clog2(COORD_BITS + 1);
  localparam int ROOT_W   = COORD_BITS + 1;
  localparam int SIDE_FW  = ROOT_W + 1;
  localparam int EXT_W    = SIDE_FW + SIDE_W + CENTRE_W;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  ctrl_t                sq_ctrl, rt_ctrl;
  logic                 out_load;

  logic [COORD_BITS-1:0] h_diff, v_diff, h_reach, v_reach;
  logic [2*COORD_BITS:0] sum_sq;
  logic [ROOT_W-1:0]     root;
  logic [EXT_W-1:0]      side_ext, centre_ext;

  // reach = max(pivot, |size - pivot|)
  always_comb begin
    h_diff  = (bitmap_width >= pivot_x) ? bitmap_width - pivot_x : pivot_x - bitmap_width;
    v_diff  = (bitmap_height >= pivot_y) ? bitmap_height - pivot_y
                                         : pivot_y - bitmap_height;
    h_reach = (pivot_x > h_diff) ? pivot_x : h_diff;
    v_reach = (pivot_y > v_diff) ? pivot_y : v_diff;
  end

  rbfs_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk     (clk),
    .ctrl    (sq_ctrl),
    .h_reach (h_reach),
    .v_reach (v_reach),
    .sum_sq  (sum_sq)
  );

  rbfs_root #(.COORD_BITS(COORD_BITS)) u_root (
    .clk      (clk),
    .ctrl     (rt_ctrl),
    .radicand (sum_sq),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    sq_ctrl      = '0;
    rt_ctrl      = '0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sq_ctrl.load = 1'b1;
          cnt_next     = '0;
          state_next   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        sq_ctrl.step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(COORD_BITS - 1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        rt_ctrl.load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_ROOT;
      end
      ST_ROOT: begin
        rt_ctrl.step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(COORD_BITS)) begin
          cnt_next   = '0;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // side = 2*root + 1, centre = root; both cut to field width
  assign side_ext   = EXT_W'({root, 1'b1});
  assign centre_ext = EXT_W'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame_side   <= side_ext[SIDE_W-1:0];
      frame_centre <= centre_ext[CENTRE_W-1:0];
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SQUARE)
    else $error("accepted transaction did not start squaring");

  a_root_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT && cnt == CNT_W'(COORD_BITS) |=> state == ST_WRITE)
    else $error("root did not finish after its last bit");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("free output register not loaded");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(COORD_BITS))
    else $error("digit counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(out_load))
    else $error("pending result overwritten");

endmodule

// ----- hdl/rbfs_square.sv -----
module rbfs_square
  import rbfs_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  ctrl_t                   ctrl,
  input  logic [COORD_BITS-1:0]   h_reach,
  input  logic [COORD_BITS-1:0]   v_reach,
  output logic [2*COORD_BITS:0]   sum_sq
);

  localparam int SUM_W = 2*COORD_BITS + 1;

  logic [COORD_BITS-1:0] h_shift, v_shift, h_mult, v_mult;
  logic [SUM_W-1:0]      acc, acc_next, h_pp, v_pp;

  // MSB-first shift-add, both squares accumulated together
  always_comb begin
    h_pp     = h_shift[COORD_BITS-1] ? SUM_W'(h_mult) : '0;
    v_pp     = v_shift[COORD_BITS-1] ? SUM_W'(v_mult) : '0;
    acc_next = {acc[SUM_W-2:0], 1'b0} + h_pp + v_pp;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      h_shift <= h_reach;
      v_shift <= v_reach;
      h_mult  <= h_reach;
      v_mult  <= v_reach;
      acc     <= '0;
    end else if (ctrl.step) begin
      h_shift <= {h_shift[COORD_BITS-2:0], 1'b0};
      v_shift <= {v_shift[COORD_BITS-2:0], 1'b0};
      acc     <= acc_next;
    end
  end

  assign sum_sq = acc;

endmodule

// ----- hdl/rbfs_root.sv -----
module rbfs_root
  import rbfs_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  ctrl_t                 ctrl,
  input  logic [2*COORD_BITS:0] radicand,
  output logic [COORD_BITS:0]   root
);

  localparam int ROOT_W = COORD_BITS + 1;
  localparam int RAD_W  = 2*ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_shift;
  logic [REM_W-1:0]  rem, rem_trial, rem_next, trial;
  logic [ROOT_W-1:0] q, q_next;

  // one root bit per cycle while step is set, two radicand bits enter the remainder
  always_comb begin
    rem_trial = {rem[REM_W-3:0], rad_shift[RAD_W-1 -: 2]};
    trial     = {1'b0, q, 2'b01};
    if (rem_trial >= trial) begin
      rem_next = rem_trial - trial;
      q_next   = {q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next = rem_trial;
      q_next   = {q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rad_shift <= RAD_W'(radicand);
      rem       <= '0;
      q         <= '0;
    end else if (ctrl.step) begin
      rad_shift <= {rad_shift[RAD_W-3:0], 2'b00};
      rem       <= rem_next;
      q         <= q_next;
    end
  end

  assign root = q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
  import rbfs_pkg::*;
();

  localparam int COORD_BITS  = 10;
  localparam int ROOT_BITS   = COORD_BITS + 1;
  localparam int N_DIRECTED  = 20;
  localparam int N_RANDOM    = 1600;
  localparam int IDLE_PCT    = 34;
  localparam int DRAIN_WAIT  = 2 * COORD_BITS + 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SIDE_W-1:0]   side;
    logic [CENTRE_W-1:0] centre;
  } frame_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  typed;
    frame_t                want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] bitmap_width = '0;
  logic [COORD_BITS-1:0] bitmap_height = '0;
  logic [COORD_BITS-1:0] pivot_x = '0;
  logic [COORD_BITS-1:0] pivot_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SIDE_W-1:0]     frame_side;
  logic [CENTRE_W-1:0]   frame_centre;

  frame_t    expected_frames[$];
  stim_row_t directed_rows[N_DIRECTED];
  int        mismatches = 0;
  int        cycles = 0;
  bit        steady = 1'b0;

  rotated_bitmap_frame_size_top #(.COORD_BITS(COORD_BITS)) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .bitmap_width (bitmap_width),
    .bitmap_height(bitmap_height),
    .pivot_x      (pivot_x),
    .pivot_y      (pivot_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_side   (frame_side),
    .frame_centre (frame_centre)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // reach per axis is the larger of the pivot and its distance to the far edge
  function automatic frame_t predict_frame(input logic [COORD_BITS-1:0] w,
                                           input logic [COORD_BITS-1:0] h,
                                           input logic [COORD_BITS-1:0] px,
                                           input logic [COORD_BITS-1:0] py);
    logic [COORD_BITS-1:0]  hr, vr, gap;
    logic [2*ROOT_BITS-1:0] sum, trial;
    logic [ROOT_BITS-1:0]   root;
    frame_t                 f;
    gap  = (w >= px) ? w - px : px - w;
    hr   = (px > gap) ? px : gap;
    gap  = (h >= py) ? h - py : py - h;
    vr   = (py > gap) ? py : gap;
    sum  = (2*ROOT_BITS)'(hr) * (2*ROOT_BITS)'(hr)
         + (2*ROOT_BITS)'(vr) * (2*ROOT_BITS)'(vr);
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = (2*ROOT_BITS)'(root) | ((2*ROOT_BITS)'(1) << b);
      if (trial * trial <= sum) root = trial[ROOT_BITS-1:0];
    end
    f.side   = SIDE_W'({root, 1'b1});
    f.centre = CENTRE_W'(root);
    return f;
  endfunction

  task automatic send_frame_request(input logic [COORD_BITS-1:0] w,
                                    input logic [COORD_BITS-1:0] h,
                                    input logic [COORD_BITS-1:0] px,
                                    input logic [COORD_BITS-1:0] py,
                                    input frame_t want);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    bitmap_width  <= w;
    bitmap_height <= h;
    pivot_x       <= px;
    pivot_y       <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_frames.push_back(want);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk)
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected transaction: frame_side %0d frame_centre %0d",
               frame_side, frame_centre);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (frame_side !== want.side) begin
          $error("frame_side: expected %0d, got %0d", want.side, frame_side);
          mismatches++;
        end
        if (frame_centre !== want.centre) begin
          $error("frame_centre: expected %0d, got %0d", want.centre, frame_centre);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [COORD_BITS-1:0] w, h, px, py;
    int                    mode;
    stim_row_t             row;

    //                 w     h     px    py  typed side   centre
    directed_rows = '{
      '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, '{12'd1,    11'd0}},
      '{10'd1023, 10'd1023, 10'd0,    10'd0,    1'b1, '{12'd2893, 11'd1446}},
      '{10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, '{12'd2893, 11'd1446}},
      '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{12'd2893, 11'd1446}},
      '{10'd1023, 10'd0,    10'd0,    10'd0,    1'b1, '{12'd2047, 11'd1023}},
      '{10'd0,    10'd1023, 10'd0,    10'd0,    1'b1, '{12'd2047, 11'd1023}},
      '{10'd3,    10'd4,    10'd0,    10'd0,    1'b1, '{12'd11,   11'd5}},
      // sum one short of a perfect square
      '{10'd2,    10'd2,    10'd0,    10'd0,    1'b1, '{12'd5,    11'd2}},
      '{10'd0,    10'd0,    10'd0,    10'd1,    1'b1, '{12'd3,    11'd1}},
      '{10'd0,    10'd1,    10'd0,    10'd0,    1'b1, '{12'd3,    11'd1}},
      // pivot beyond the bitmap edge
      '{10'd5,    10'd5,    10'd20,   10'd3,    1'b0, '{12'd0,    11'd0}},
      '{10'd600,  10'd700,  10'd1023, 10'd1023, 1'b0, '{12'd0,    11'd0}},
      '{10'd100,  10'd60,   10'd50,   10'd30,   1'b0, '{12'd0,    11'd0}},
      '{10'd1,    10'd1,    10'd0,    10'd0,    1'b0, '{12'd0,    11'd0}},
      '{10'd512,  10'd512,  10'd256,  10'd256,  1'b0, '{12'd0,    11'd0}},
      '{10'h2AA,  10'h155,  10'h155,  10'h2AA,  1'b0, '{12'd0,    11'd0}},
      '{10'h155,  10'h2AA,  10'h2AA,  10'h155,  1'b0, '{12'd0,    11'd0}},
      '{10'd7,    10'd24,   10'd0,    10'd0,    1'b0, '{12'd0,    11'd0}},
      '{10'd15,   10'd0,    10'd0,    10'd0,    1'b0, '{12'd0,    11'd0}},
      '{10'd1000, 10'd3,    10'd999,  10'd2,    1'b0, '{12'd0,    11'd0}}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      send_frame_request(row.w, row.h, row.px, row.py,
                         row.typed ? row.want : predict_frame(row.w, row.h, row.px, row.py));
    end
    hold_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 400 && i < 700);
      if (i == 800) hold_until_drained();
      mode = $urandom_range(9);
      if (mode <= 5) begin
        // the usual case: pivot inside the bitmap
        w  = COORD_BITS'($urandom_range(1023));
        h  = COORD_BITS'($urandom_range(1023));
        px = COORD_BITS'($urandom_range(w));
        py = COORD_BITS'($urandom_range(h));
      end else if (mode <= 7) begin
        w  = COORD_BITS'($urandom_range(1023));
        h  = COORD_BITS'($urandom_range(1023));
        px = COORD_BITS'($urandom_range(1023));
        py = COORD_BITS'($urandom_range(1023));
      end else if (mode == 8) begin
        w  = COORD_BITS'($urandom_range(15));
        h  = COORD_BITS'($urandom_range(15));
        px = COORD_BITS'($urandom_range(15));
        py = COORD_BITS'($urandom_range(15));
      end else begin
        w  = COORD_BITS'($urandom_range(1) ? 1023 - $urandom_range(1) : $urandom_range(1));
        h  = COORD_BITS'($urandom_range(1) ? 1023 - $urandom_range(1) : $urandom_range(1));
        px = COORD_BITS'($urandom_range(1) ? 1023 - $urandom_range(1) : $urandom_range(1));
        py = COORD_BITS'($urandom_range(1) ? 1023 - $urandom_range(1) : $urandom_range(1));
      end
      send_frame_request(w, h, px, py, predict_frame(w, h, px, py));
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
